// ===== rtl/core/npc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npc_pkg
// Types, codes and helpers shared by the nearest palette color core.
// ----------------------------------------------------------------------------
package npc_pkg;

  localparam int CHAN_W    = 8;
  localparam int INDEX_W   = 8;
  localparam int LEN_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int DIST_W    = 18;

  localparam logic [DIST_W-1:0] START_DISTANCE = 18'd200000;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_COLORS_USED      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLORS_IMPORTANT = 2'd1;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } rgb_t;

  typedef struct packed {
    logic [CHAN_W-1:0] alpha;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } rgba_t;

  typedef struct packed {
    logic               action;
    logic [INDEX_W-1:0] entry_index;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic [CHAN_W-1:0]  alpha;
  } req_t;

  typedef struct packed {
    logic [INDEX_W-1:0] nearest_index;
  } rsp_t;

  // search token walking down the row of cells
  typedef struct packed {
    logic               valid;
    logic               done;
    rgb_t               color;
    logic [DIST_W-1:0]  best;
    logic [INDEX_W-1:0] pick;
  } token_t;

  function automatic logic [2*CHAN_W-1:0] sq_diff(input logic [CHAN_W-1:0] p,
                                                  input logic [CHAN_W-1:0] q);
    logic [CHAN_W-1:0] d;
    d = (p > q) ? (p - q) : (q - p);
    return (2*CHAN_W)'(d) * (2*CHAN_W)'(d);
  endfunction

endpackage

// ===== rtl/core/npc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npc_if
// Valid/ready channels of the nearest palette color core.
// ----------------------------------------------------------------------------
interface npc_req_if;
  logic          valid;
  logic          ready;
  npc_pkg::req_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

interface npc_rsp_if;
  logic          valid;
  logic          ready;
  npc_pkg::rsp_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

interface npc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [npc_pkg::CFG_IDX_W-1:0]  index;
  logic [npc_pkg::LEN_W-1:0]      data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/npc_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npc_cell
// One palette entry with its distance unit; updates the passing search token.
// ----------------------------------------------------------------------------
module npc_cell #(
  parameter int CELL_INDEX = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  logic [npc_pkg::LEN_W-1:0]   scan_len,
  input  logic                        wr_en,
  input  npc_pkg::rgb_t               wr_color,
  input  npc_pkg::token_t             tok_in,
  output npc_pkg::token_t             tok_out
);

  localparam logic [npc_pkg::LEN_W-1:0] MY_INDEX = npc_pkg::LEN_W'(CELL_INDEX);

  npc_pkg::rgb_t                  entry;
  npc_pkg::token_t                tok_next;
  logic [npc_pkg::DIST_W-1:0]     sq_sum;
  logic                           active;

  always_comb begin
    sq_sum = npc_pkg::DIST_W'(npc_pkg::sq_diff(entry.red, tok_in.color.red))
           + npc_pkg::DIST_W'(npc_pkg::sq_diff(entry.green, tok_in.color.green))
           + npc_pkg::DIST_W'(npc_pkg::sq_diff(entry.blue, tok_in.color.blue));
    active = tok_in.valid && !tok_in.done && (MY_INDEX < scan_len);
    tok_next = tok_in;
    if (active) begin
      if (sq_sum == '0) begin
        tok_next.done = 1'b1;
        tok_next.pick = MY_INDEX[npc_pkg::INDEX_W-1:0];
      end else if (sq_sum < tok_in.best) begin
        tok_next.best = sq_sum;
        tok_next.pick = MY_INDEX[npc_pkg::INDEX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else if (wr_en) begin
      entry <= wr_color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else if (advance) begin
      tok_out <= tok_next;
    end
  end

endmodule

// ===== rtl/core/nearest_palette_color_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_palette_color_core
// Palette of RGB entries held in a row of cells; a query token walks the row
// and picks the entry at least squared distance, with a last-query cache.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                    request
//  req      in   action, entry_index, red, green, blue, alpha  valid & ready
//  rsp      out  nearest_index                               valid & ready
//  cfg      in   index, data (colors_used, colors_important) valid & ready
//
// a write in range is stored as it is taken; every query, hit or miss, walks all
// PALETTE_DEPTH cells, one per cycle while the row is not held; its response is
// registered as its token leaves the last cell, and the next request is taken from then on
// reset clears all entries, the cache and both registers
// a stalled response with a token at the end holds the row; writes wait while a query is out
module nearest_palette_color_core #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic            clk,
  input  logic            rst,
  npc_req_if.sink         req,
  npc_rsp_if.source       rsp,
  npc_cfg_if.sink         cfg
);

  localparam logic [npc_pkg::LEN_W-1:0] DEPTH_LEN = npc_pkg::LEN_W'(PALETTE_DEPTH);

  logic [npc_pkg::LEN_W-1:0]   colors_used;
  logic [npc_pkg::LEN_W-1:0]   colors_important;
  logic                        busy;
  logic                        fill_cache;
  logic                        cache_valid;
  npc_pkg::rgba_t              cached_color;
  logic [npc_pkg::INDEX_W-1:0] cached_index;
  logic                        rsp_valid;
  logic [npc_pkg::INDEX_W-1:0] rsp_index;

  npc_pkg::token_t             chain [PALETTE_DEPTH+1];
  npc_pkg::token_t             tail;
  npc_pkg::rgba_t              query_color;
  logic [npc_pkg::LEN_W-1:0]   scan_len;
  logic [npc_pkg::LEN_W-1:0]   wr_index;
  logic                        req_fire;
  logic                        query_fire;
  logic                        wr_fire;
  logic                        no_palette;
  logic                        cache_hit;
  logic                        advance;
  logic                        tail_fire;

  assign req.ready   = !busy;
  assign cfg.ready   = 1'b1;
  assign rsp.valid   = rsp_valid;
  assign rsp.payload.nearest_index = rsp_index;

  assign req_fire    = req.valid && req.ready;
  assign query_fire  = req_fire && (req.payload.action == npc_pkg::ACT_QUERY);
  assign wr_index    = npc_pkg::LEN_W'(req.payload.entry_index);
  assign no_palette  = (colors_used == '0);
  assign wr_fire     = req_fire && (req.payload.action == npc_pkg::ACT_WRITE)
                       && !no_palette && (wr_index < colors_used) && (wr_index < DEPTH_LEN);

  assign query_color.red   = req.payload.red;
  assign query_color.green = req.payload.green;
  assign query_color.blue  = req.payload.blue;
  assign query_color.alpha = req.payload.alpha;

  assign cache_hit = cache_valid && (cached_color == query_color);
  assign scan_len  = (colors_important != '0) ? colors_important : colors_used;

  assign tail      = chain[PALETTE_DEPTH];
  assign advance   = !(tail.valid && rsp_valid && !rsp.ready);
  assign tail_fire = tail.valid && advance;

  always_comb begin
    chain[0].valid       = query_fire;
    chain[0].done        = no_palette || cache_hit;
    chain[0].color.red   = req.payload.red;
    chain[0].color.green = req.payload.green;
    chain[0].color.blue  = req.payload.blue;
    chain[0].best        = npc_pkg::START_DISTANCE;
    chain[0].pick        = (!no_palette && cache_hit) ? cached_index : '0;
  end

  for (genvar i = 0; i < PALETTE_DEPTH; i++) begin : g_cell
    npc_cell #(
      .CELL_INDEX(i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .scan_len (scan_len),
      .wr_en    (wr_fire && (req.payload.entry_index == npc_pkg::INDEX_W'(i))),
      .wr_color (chain[0].color),
      .tok_in   (chain[i]),
      .tok_out  (chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      colors_used      <= '0;
      colors_important <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        npc_pkg::REG_COLORS_USED:      colors_used      <= cfg.data;
        npc_pkg::REG_COLORS_IMPORTANT: colors_important <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      fill_cache   <= 1'b0;
      cache_valid  <= 1'b0;
      cached_color <= '0;
      cached_index <= '0;
    end else begin
      if (wr_fire) begin
        cache_valid <= 1'b0;
      end
      if (query_fire) begin
        busy <= 1'b1;
        if (!no_palette && !cache_hit) begin
          fill_cache   <= 1'b1;
          cache_valid  <= 1'b1;
          cached_color <= query_color;
        end
      end
      if (tail_fire) begin
        busy       <= 1'b0;
        fill_cache <= 1'b0;
        if (fill_cache) begin
          cached_index <= tail.pick;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (tail_fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tail_fire) begin
      rsp_index <= tail.pick;
    end
  end

endmodule

// ===== rtl/core/npc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npc_checker
// Port-level checks of the nearest palette color core, bound to the top.
// ----------------------------------------------------------------------------
module npc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         req_action,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [npc_pkg::INDEX_W-1:0]  rsp_index
);

  // stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_index))
    else $error("response dropped or changed under stall");

  // nothing to deliver right after reset
  a_rsp_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

  // a query occupies the row
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_action == npc_pkg::ACT_QUERY) |=> !req_ready)
    else $error("request taken while a query is in flight");

  // a write never produces a response
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_action == npc_pkg::ACT_WRITE) && !rsp_valid
    |=> !rsp_valid)
    else $error("response after a write");

endmodule

bind nearest_palette_color_core npc_checker u_npc_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .req_action (req.payload.action),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_index  (rsp.payload.nearest_index)
);

// ===== bench/nearest_color_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_color_checker
// Watches the request, response and register channels of the nearest palette
// color core, keeps its own palette, cache and register copies, works out the
// index each query should return and compares every response against it.
// ----------------------------------------------------------------------------
module nearest_color_checker #(
  parameter int DEPTH = 256
) (
  input  logic clk,
  input  logic rst,
  npc_req_if   req,
  npc_rsp_if   rsp,
  npc_cfg_if   cfg,
  output int   mismatches,
  output int   outstanding,
  output int   queries_seen,
  output int   cache_hits,
  output int   writes_stored,
  output int   writes_dropped
);
  import npc_pkg::*;

  rgba_t              palette_mem [DEPTH];
  rgba_t              last_color;
  logic               last_valid;
  logic [INDEX_W-1:0] last_pick;
  logic [LEN_W-1:0]   used_r;
  logic [LEN_W-1:0]   important_r;
  logic [INDEX_W-1:0] expected_index_q [$];

  task automatic report_mismatch(input string what);
    if (mismatches < 100) $display("%0t mismatch: %s", $time, what);
    mismatches++;
  endtask

  // first entry at least squared rgb distance, exact match stops the walk
  function automatic logic [INDEX_W-1:0] nearest_entry(input rgba_t c);
    int span, best, sq_sum, pick, dr, dg, db, i;
    span = (important_r != 0) ? int'(important_r) : int'(used_r);
    if (span > DEPTH) span = DEPTH;
    best = int'(START_DISTANCE);
    pick = 0;
    for (i = 0; i < span; i++) begin
      dr = int'(palette_mem[i].red) - int'(c.red);
      dg = int'(palette_mem[i].green) - int'(c.green);
      db = int'(palette_mem[i].blue) - int'(c.blue);
      sq_sum = dr * dr + dg * dg + db * db;
      if (sq_sum == 0) begin
        pick = i;
        break;
      end
      if (sq_sum < best) begin
        best = sq_sum;
        pick = i;
      end
    end
    return INDEX_W'(pick);
  endfunction

  always @(posedge clk) begin
    req_t               item;
    rgba_t              color;
    logic [INDEX_W-1:0] want;
    if (rst) begin
      foreach (palette_mem[k]) palette_mem[k] = '0;
      last_color = '0;
      last_valid = 1'b0;
      last_pick = '0;
      used_r = '0;
      important_r = '0;
      expected_index_q.delete();
      mismatches = 0;
      queries_seen = 0;
      cache_hits = 0;
      writes_stored = 0;
      writes_dropped = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_COLORS_USED:      used_r = cfg.data;
          REG_COLORS_IMPORTANT: important_r = cfg.data;
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_index_q.size() == 0) begin
          report_mismatch($sformatf("response index %0d with no query waiting",
                                    rsp.payload.nearest_index));
        end else begin
          want = expected_index_q.pop_front();
          if (rsp.payload.nearest_index !== want)
            report_mismatch($sformatf("nearest_index got %0d want %0d",
                                      rsp.payload.nearest_index, want));
        end
      end
      if (req.valid && req.ready) begin
        item = req.payload;
        color.red = item.red;
        color.green = item.green;
        color.blue = item.blue;
        color.alpha = item.alpha;
        if (item.action == ACT_WRITE) begin
          if (used_r != 0 && item.entry_index < used_r && int'(item.entry_index) < DEPTH) begin
            palette_mem[item.entry_index] = color;
            last_valid = 1'b0;
            writes_stored++;
          end else begin
            writes_dropped++;
          end
        end else begin
          queries_seen++;
          if (used_r == 0) begin
            expected_index_q.push_back('0);
          end else if (last_valid && last_color == color) begin
            expected_index_q.push_back(last_pick);
            cache_hits++;
          end else begin
            last_color = color;
            last_valid = 1'b1;
            last_pick = nearest_entry(color);
            expected_index_q.push_back(last_pick);
          end
        end
      end
    end
    outstanding = expected_index_q.size();
  end

endmodule

// ===== bench/nearest_palette_color_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_palette_color_core_tb
// Drives palette writes, color queries and register settings into the core
// with bursty requests and a stalling response side; the checker beside the
// core predicts every answer and the verdict comes from its failure and outstanding counts.
// ----------------------------------------------------------------------------
module nearest_palette_color_core_tb;
  import npc_pkg::*;

  localparam int DEPTH         = 256;
  localparam int TOTAL_ITEMS   = 1150;
  localparam int SETTLE_CYCLES = 16;
  localparam int QUIET_LIMIT   = 2000;

  typedef enum int {RX_OPEN, RX_COIN, RX_EVERY_FOURTH, RX_BURSTS} rx_mode_e;

  logic clk = 1'b0;
  logic rst = 1'b1;

  npc_req_if req_ch();
  npc_rsp_if rsp_ch();
  npc_cfg_if cfg_ch();

  int mismatches, outstanding, queries_seen, cache_hits, writes_stored, writes_dropped;
  int items_sent, reg_writes, burst_left, quiet;
  int cur_used, cur_imp;
  bit steady;
  rgba_t stored_colors [$];
  rgba_t last_query;
  rx_mode_e rx_mode = RX_OPEN;
  int rx_window, hold_left, beat;

  nearest_palette_color_core #(.PALETTE_DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  nearest_color_checker #(.DEPTH(DEPTH)) answer_check (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch),
    .mismatches(mismatches),
    .outstanding(outstanding),
    .queries_seen(queries_seen),
    .cache_hits(cache_hits),
    .writes_stored(writes_stored),
    .writes_dropped(writes_dropped)
  );

  always #5 clk = ~clk;

  // response stall pattern
  always @(negedge clk) begin
    logic ready_next;
    if (rx_window == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_window = $urandom_range(20, 400);
    end else begin
      rx_window--;
    end
    beat++;
    case (rx_mode)
      RX_OPEN:         ready_next = 1'b1;
      RX_COIN:         ready_next = $urandom_range(0, 1);
      RX_EVERY_FOURTH: ready_next = (beat % 4 == 0);
      default: begin
        if (hold_left > 0) begin
          ready_next = 1'b0;
          hold_left--;
        end else begin
          ready_next = 1'b1;
          if ($urandom_range(0, 1)) hold_left = $urandom_range(1, 12);
        end
      end
    endcase
    rsp_ch.ready <= ready_next;
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic rgba_t color_of(input int r, input int g, input int b, input int a);
    rgba_t c;
    c.red = r[7:0];
    c.green = g[7:0];
    c.blue = b[7:0];
    c.alpha = a[7:0];
    return c;
  endfunction

  function automatic rgba_t extreme_color();
    rgba_t c;
    c.red = $urandom_range(0, 1) ? 8'hff : 8'h00;
    c.green = $urandom_range(0, 1) ? 8'hff : 8'h00;
    c.blue = $urandom_range(0, 1) ? 8'hff : 8'h00;
    c.alpha = $urandom_range(0, 1) ? 8'hff : 8'h00;
    return c;
  endfunction

  function automatic logic [7:0] jitter(input logic [7:0] v);
    int t;
    t = int'(v) + int'($urandom_range(0, 6)) - 3;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return t[7:0];
  endfunction

  function automatic rgba_t palette_color();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 15 && stored_colors.size() > 0)
      return stored_colors[$urandom_range(0, stored_colors.size() - 1)];
    if (pick < 30) return extreme_color();
    return rgba_t'($urandom);
  endfunction

  function automatic rgba_t query_color();
    rgba_t c;
    rgba_t base;
    c = rgba_t'($urandom);
    base = (stored_colors.size() > 0) ?
           stored_colors[$urandom_range(0, stored_colors.size() - 1)] : c;
    case ($urandom_range(0, 9))
      0, 1, 2: ;
      3, 4: begin
        c.red = base.red;
        c.green = base.green;
        c.blue = base.blue;
      end
      5: begin
        c.red = jitter(base.red);
        c.green = jitter(base.green);
        c.blue = jitter(base.blue);
      end
      6: c = last_query;
      7: begin
        c.red = last_query.red;
        c.green = last_query.green;
        c.blue = last_query.blue;
      end
      8: c = extreme_color();
      default: c = base;
    endcase
    return c;
  endfunction

  task automatic pause(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
    end
  endtask

  task automatic issue(input logic action, input int idx, input rgba_t c);
    req_t item;
    item.action = action;
    item.entry_index = INDEX_W'(idx);
    item.red = c.red;
    item.green = c.green;
    item.blue = c.blue;
    item.alpha = c.alpha;
    if (burst_left == 0) begin
      if (!steady) pause($urandom_range(1, 8));
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    req_ch.valid <= 1'b1;
    req_ch.payload <= item;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    items_sent++;
    if (action == ACT_WRITE) begin
      stored_colors.push_back(c);
      if (stored_colors.size() > 32) void'(stored_colors.pop_front());
    end else begin
      last_query = c;
    end
  endtask

  // hold requests until every answer is back and the core has gone quiet
  task automatic settle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= LEN_W'(value);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    reg_writes++;
  endtask

  task automatic set_ranges(input int used, input int imp);
    settle();
    if ($urandom_range(0, 1)) begin
      write_register(REG_COLORS_USED, used);
      write_register(REG_COLORS_IMPORTANT, imp);
    end else begin
      write_register(REG_COLORS_IMPORTANT, imp);
      write_register(REG_COLORS_USED, used);
    end
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    cur_used = used;
    cur_imp = imp;
  endtask

  initial begin
    int phase_len, write_pct, pressure_at, idx, span, k;
    bit pressed;
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    rsp_ch.ready = 1'b0;
    last_query = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // no palette: writes dropped, queries answer zero
    issue(ACT_WRITE, 7, color_of(1, 2, 3, 4));
    issue(ACT_QUERY, 0, color_of(0, 0, 0, 0));
    issue(ACT_QUERY, 255, color_of(255, 255, 255, 255));

    set_ranges(256, 0);
    issue(ACT_WRITE, 0, color_of(255, 255, 255, 255));
    issue(ACT_WRITE, 3, color_of(10, 20, 30, 0));
    issue(ACT_WRITE, 4, color_of(10, 20, 30, 0));
    issue(ACT_WRITE, 5, color_of(200, 100, 50, 128));
    issue(ACT_WRITE, 255, color_of(0, 0, 0, 255));
    issue(ACT_QUERY, 0, color_of(255, 255, 255, 255));
    issue(ACT_QUERY, 0, color_of(12, 20, 30, 7));
    issue(ACT_QUERY, 0, color_of(12, 20, 30, 7));
    issue(ACT_QUERY, 0, color_of(12, 20, 30, 8));
    issue(ACT_QUERY, 0, color_of(0, 0, 0, 0));
    issue(ACT_QUERY, 0, color_of(199, 101, 50, 0));

    // cache survives a register change and dropped writes
    set_ranges(4, 0);
    issue(ACT_QUERY, 0, color_of(199, 101, 50, 0));
    issue(ACT_WRITE, 4, color_of(1, 1, 1, 1));
    issue(ACT_WRITE, 255, color_of(2, 2, 2, 2));
    issue(ACT_QUERY, 0, color_of(199, 101, 50, 0));

    // scan length past the palette depth
    set_ranges(4, 511);
    issue(ACT_QUERY, 0, color_of(200, 100, 50, 128));

    set_ranges(511, 1);
    issue(ACT_QUERY, 0, color_of(1, 1, 1, 1));
    issue(ACT_WRITE, 255, color_of(9, 9, 9, 9));

    // important above used reaches entries past the used count
    set_ranges(2, 256);
    issue(ACT_QUERY, 0, color_of(9, 9, 9, 9));

    pressed = 1'b0;
    while (items_sent < TOTAL_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       cur_used = 0;
        1:       cur_used = 1;
        2:       cur_used = 2;
        3, 9:    cur_used = $urandom_range(3, 16);
        4, 5:    cur_used = $urandom_range(17, 255);
        6:       cur_used = 256;
        7:       cur_used = $urandom_range(257, 510);
        default: cur_used = 511;
      endcase
      case ($urandom_range(0, 7))
        0, 1, 2, 3: cur_imp = 0;
        4:          cur_imp = 1;
        5:          cur_imp = $urandom_range(1, (cur_used + 8 > 511) ? 511 : cur_used + 8);
        6:          cur_imp = 256;
        default:    cur_imp = $urandom_range(0, 511);
      endcase
      set_ranges(cur_used, cur_imp);
      phase_len = $urandom_range(50, 130);
      write_pct = $urandom_range(20, 70);
      steady = ($urandom_range(0, 3) == 0);
      pressure_at = (!pressed || $urandom_range(0, 2) == 0) ?
                    int'($urandom_range(0, phase_len - 1)) : -1;
      span = (cur_used > DEPTH) ? DEPTH : cur_used;
      for (k = 0; k < phase_len && items_sent < TOTAL_ITEMS; k++) begin
        if (k == pressure_at) begin
          settle();
          pressed = 1'b1;
        end
        if ($urandom_range(0, 99) < write_pct) begin
          if (span > 0 && $urandom_range(0, 99) < 85) idx = $urandom_range(0, span - 1);
          else idx = $urandom_range(0, 255);
          issue(ACT_WRITE, idx, palette_color());
        end else begin
          issue(ACT_QUERY, $urandom_range(0, 255), query_color());
        end
      end
    end

    settle();
    repeat (DEPTH + 24) @(negedge clk);
    $display("covered %0d queries (%0d answered from the cache), %0d palette writes kept, %0d dropped",
             queries_seen, cache_hits, writes_stored, writes_dropped);
    $display("%0d register writes took used and important counts through 0, 1, 256, 511 and more",
             reg_writes);
    if (mismatches == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/npc_pkg.sv
rtl/core/npc_if.sv
rtl/core/npc_cell.sv
rtl/core/nearest_palette_color_core.sv
rtl/core/npc_checker.sv
bench/nearest_color_checker.sv
bench/nearest_palette_color_core_tb.sv
